// ===== sv/miq_pkg.sv =====
package miq_pkg;

    localparam int BLOCK_SIZE_DEF = 64;

    localparam int COEF_IN_W  = 12;
    localparam int WEIGHT_W   = 8;
    localparam int SCALE_W    = 7;
    localparam int COEF_OUT_W = 16;

    // s_tdata: coef_in, weight, quant_scale, zero fill to 32 bits
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    // (2|q|+1) operand, scale product, weight product
    localparam int OPND_W     = COEF_IN_W + 1;
    localparam int PROD1_W    = OPND_W + SCALE_W;
    localparam int PROD2_W    = PROD1_W + WEIGHT_W;
    localparam int SHIFT_W    = PROD2_W - 4;
    localparam int MAG_W      = COEF_OUT_W - 1;

    // one command per datapath step
    typedef struct packed {
        logic load;
        logic mul_scale;
        logic mul_weight;
        logic commit;
    } miq_cmd_t;

endpackage

// ===== sv/miq_ctrl.sv =====
module miq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output miq_pkg::miq_cmd_t cmd
);
    import miq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_WGT  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   s_accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    // output register can take a new result when empty or draining
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_accept;
                if (s_accept) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_scale = 1'b1;
                state_next    = ST_WGT;
            end
            ST_WGT: begin
                cmd.mul_weight = 1'b1;
                state_next     = ST_FIN;
            end
            ST_FIN: begin
                cmd.commit = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_MUL)
        else $error("accepted item did not start the multiply");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed result not presented");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && m_tvalid_reg && !m_tready) |=> state_reg == ST_FIN)
        else $error("result overwritten while output stalled");

endmodule

// ===== sv/miq_dp.sv =====
module miq_dp #(
    parameter int BLOCK_SIZE = miq_pkg::BLOCK_SIZE_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  miq_pkg::miq_cmd_t                    cmd,
    input  logic signed [miq_pkg::COEF_IN_W-1:0] coef_in,
    input  logic [miq_pkg::WEIGHT_W-1:0]         weight,
    input  logic [miq_pkg::SCALE_W-1:0]          quant_scale,
    input  logic                                 is_intra,
    output logic signed [miq_pkg::COEF_OUT_W-1:0] coef_out,
    output logic                                 last_of_block
);
    import miq_pkg::*;

    localparam int POS_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

    logic signed [COEF_IN_W-1:0]  q_reg;
    logic [WEIGHT_W-1:0]          weight_reg;
    logic [SCALE_W-1:0]           scale_reg;
    logic                         intra_reg;
    logic [PROD1_W-1:0]           p1_reg;
    logic [PROD2_W-1:0]           p2_reg;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic                         parity_reg, parity_next;
    logic signed [COEF_OUT_W-1:0] out_data_reg;
    logic                         out_last_reg;

    logic                  neg;
    logic [COEF_IN_W-1:0]  mag;
    logic [OPND_W-1:0]     opnd;
    logic [SHIFT_W-1:0]    shifted;
    logic [MAG_W-1:0]      sat_mag;
    logic [COEF_OUT_W-1:0] mag16;
    logic [COEF_OUT_W-1:0] res;
    logic                  is_dc;
    logic                  last;
    logic                  par_acc;

    assign neg  = q_reg[COEF_IN_W-1];
    // -(-2048) wraps to 12'h800, the right unsigned magnitude
    assign mag  = neg ? COEF_IN_W'(-q_reg) : COEF_IN_W'(q_reg);
    assign opnd = intra_reg ? {1'b0, mag} : {mag, 1'b1};

    assign shifted = intra_reg ? p2_reg[PROD2_W-1:4] : {1'b0, p2_reg[PROD2_W-1:5]};
    assign sat_mag = (|shifted[SHIFT_W-1:MAG_W]) ? {MAG_W{1'b1}} : shifted[MAG_W-1:0];
    // non-intra zero input must stay zero (operand 1 alone would not)
    assign mag16   = (!intra_reg && q_reg == '0) ? '0 : {1'b0, sat_mag};

    assign is_dc = intra_reg && (pos_reg == '0);
    assign last  = (pos_reg == POS_W'(BLOCK_SIZE - 1));

    always_comb begin
        if (is_dc) begin
            res = {{(COEF_OUT_W-COEF_IN_W){q_reg[COEF_IN_W-1]}}, q_reg};
        end else if (neg) begin
            res = COEF_OUT_W'(-mag16);
        end else begin
            res = mag16;
        end
        par_acc = parity_reg ^ res[0];
        if (last) begin
            pos_next    = '0;
            parity_next = 1'b1;
        end else begin
            pos_next    = pos_reg + POS_W'(1);
            parity_next = par_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            parity_reg <= 1'b1;
        end else if (cmd.commit) begin
            pos_reg    <= pos_next;
            parity_reg <= parity_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            q_reg      <= coef_in;
            weight_reg <= weight;
            scale_reg  <= quant_scale;
            intra_reg  <= is_intra;
        end
        if (cmd.mul_scale) begin
            p1_reg <= PROD1_W'(opnd) * PROD1_W'(scale_reg);
        end
        if (cmd.mul_weight) begin
            p2_reg <= PROD2_W'(p1_reg) * PROD2_W'(weight_reg);
        end
        if (cmd.commit) begin
            // mismatch control flips the LSB of the last coefficient when par_acc is set
            out_data_reg <= last ? (res ^ {{(COEF_OUT_W-1){1'b0}}, par_acc}) : res;
            out_last_reg <= last;
        end
    end

    assign coef_out      = out_data_reg;
    assign last_of_block = out_last_reg;

    a_block_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && last) |=> (pos_reg == '0 && parity_reg))
        else $error("block end did not reset position and parity");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !last) |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("position did not advance");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_last_reg == $past(last))
        else $error("last flag mismatch");

endmodule

// ===== sv/mpeg2_inverse_quant.sv =====
// MPEG-2 inverse quantizer with mismatch control, one coefficient per item.
// Input accept loads the operands, then the scale multiply, weight multiply and
// saturate/parity commit states follow in order, the commit registering m_tvalid;
// a new item is accepted only after the commit, and output stalls hold the commit.
// The next item is accepted while a result waits in the output register.
// Reset (aresetn low, synchronous): controller idle, position 0, parity 1.
module mpeg2_inverse_quant #(
    parameter int BLOCK_SIZE = miq_pkg::BLOCK_SIZE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [miq_pkg::S_TDATA_W-1:0]   s_tdata,  // coef_in[11:0], weight[19:12], quant_scale[26:20]
    input  logic                            s_tuser,  // is_intra
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [miq_pkg::M_TDATA_W-1:0]   m_tdata,  // coef_out[15:0]
    output logic                            m_tlast
);
    import miq_pkg::*;

    miq_cmd_t                     cmd;
    logic signed [COEF_OUT_W-1:0] coef_out;

    miq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    miq_dp #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .coef_in       ($signed(s_tdata[COEF_IN_W-1:0])),
        .weight        (s_tdata[COEF_IN_W+WEIGHT_W-1:COEF_IN_W]),
        .quant_scale   (s_tdata[COEF_IN_W+WEIGHT_W+SCALE_W-1:COEF_IN_W+WEIGHT_W]),
        .is_intra      (s_tuser),
        .coef_out      (coef_out),
        .last_of_block (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(coef_out);

endmodule

// ===== dv/tb_mpeg2_inverse_quant.sv =====
`timescale 1ns / 100ps

module tb_mpeg2_inverse_quant;

    import miq_pkg::*;

    localparam int BLK       = BLOCK_SIZE_DEF;
    localparam int IDLE_PCT  = 30;
    localparam int QUIET_LO  = 600;
    localparam int QUIET_HI  = 800;

    typedef struct {
        logic [COEF_IN_W-1:0] coef;
        logic [WEIGHT_W-1:0]  weight;
        logic [SCALE_W-1:0]   scale;
        logic                 intra;
        bit                   drain;   // hold off until all results are back
    } coef_item_t;

    typedef struct {
        logic [COEF_OUT_W-1:0] coef;
        logic                  last;
    } dq_coef_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;  // coef_in[11:0], weight[19:12], quant_scale[26:20]
    logic                  s_tuser  = 1'b0; // is_intra
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // coef_out[15:0]
    logic                  m_tlast;

    coef_item_t coef_stim_q[$];
    dq_coef_t   exp_coef_q[$];
    coef_item_t cur_item;
    bit         in_taken   = 1'b0;
    int         acc_cnt    = 0;
    int         res_cnt    = 0;
    int         err_cnt    = 0;
    int         blk_pos    = 0;
    logic       blk_parity = 1'b1;

    mpeg2_inverse_quant dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Dequantize one accepted item and advance block position / mismatch parity.
    task automatic dequantize(input coef_item_t it);
        int          qv;
        int unsigned mag;
        int unsigned m;
        int unsigned s;
        int unsigned w;
        dq_coef_t    r;
        begin
            qv  = int'($signed(it.coef));
            mag = (qv < 0) ? -qv : qv;
            s   = it.scale;
            w   = it.weight;
            if (it.intra && blk_pos == 0) begin
                r.coef = 16'(qv);
            end else begin
                if (it.intra)
                    m = (mag * s * w) >> 4;
                else if (qv == 0)
                    m = 0;
                else
                    m = ((2 * mag + 1) * s * w) >> 5;
                if (m > 32767)
                    m = 32767;
                r.coef = (qv < 0) ? 16'(32'd0 - m) : 16'(m);
            end
            blk_parity = blk_parity ^ r.coef[0];
            r.last = (blk_pos >= BLK - 1);
            if (r.last) begin
                r.coef[0]  = r.coef[0] ^ blk_parity;
                blk_pos    = 0;
                blk_parity = 1'b1;
            end else begin
                blk_pos++;
            end
            exp_coef_q.push_back(r);
        end
    endtask

    function automatic logic [COEF_IN_W-1:0] rand_coef();
        int v;
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: v = 0;
                4, 5, 6:    v = $urandom_range(30) - 15;
                7:          v = $urandom_range(4095) - 2048;
                8: begin
                    case ($urandom_range(3))
                        0: v = -2048;
                        1: v = 2047;
                        2: v = 1;
                        default: v = -1;
                    endcase
                end
                default:    v = $urandom_range(510) - 255;
            endcase
            return 12'(v);
        end
    endfunction

    // Items for block positions first_pos..BLK-1; noisy blocks vary intra and scale per item.
    task automatic gen_block(input int first_pos, input bit noisy);
        coef_item_t  it;
        logic        intra;
        logic [6:0]  scale;
        begin
            intra = 1'($urandom_range(1));
            case ($urandom_range(9))
                0:       scale = 7'd0;
                1:       scale = 7'd127;
                2:       scale = 7'($urandom_range(127, 113));
                default: scale = 7'($urandom_range(112, 1));
            endcase
            for (int p = first_pos; p < BLK; p++) begin
                it.coef   = rand_coef();
                it.weight = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
                it.scale  = noisy ? 7'($urandom_range(127)) : scale;
                it.intra  = noisy ? 1'($urandom_range(1)) : intra;
                it.drain  = 1'b0;
                // push the last coefficient into saturation now and then
                if (p == BLK - 1 && $urandom_range(3) == 0) begin
                    it.coef   = $urandom_range(1) ? 12'h7FF : 12'h800;
                    it.weight = 8'd255;
                end
                coef_stim_q.push_back(it);
            end
        end
    endtask

    task automatic add_item(input int q, input int w, input int s, input bit intra);
        coef_item_t it;
        begin
            it.coef   = 12'(q);
            it.weight = 8'(w);
            it.scale  = 7'(s);
            it.intra  = intra;
            it.drain  = 1'b0;
            coef_stim_q.push_back(it);
        end
    endtask

    // stimulus driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (coef_stim_q.size() != 0
                && !(coef_stim_q[0].drain && exp_coef_q.size() != 0)
                && ((acc_cnt >= QUIET_LO && acc_cnt < QUIET_HI)
                    || $urandom_range(99) >= IDLE_PCT)) begin
                cur_item = coef_stim_q.pop_front();
                s_tdata  <= {5'b0, cur_item.scale, cur_item.weight, cur_item.coef};
                s_tuser  <= cur_item.intra;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= (res_cnt >= QUIET_LO && res_cnt < QUIET_HI)
                    || $urandom_range(99) >= IDLE_PCT;
    end

    // monitor and checker
    always @(posedge aclk) begin
        dq_coef_t want;
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                dequantize(cur_item);
                acc_cnt++;
            end
            if (m_tvalid && m_tready) begin
                res_cnt++;
                if (exp_coef_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected item coef_out=%h last=%b",
                                 $realtime, m_tdata, m_tlast);
                end else begin
                    want = exp_coef_q.pop_front();
                    if (m_tdata !== want.coef || m_tlast !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: item %0d coef_out exp %h got %h, last exp %b got %b",
                                     $realtime, res_cnt - 1, want.coef, m_tdata,
                                     want.last, m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        // directed: DC passthrough, saturation, zero weight/scale, both rules, intra flip mid-block
        add_item(-2048, 255, 127, 1'b1);
        add_item( 2047, 255, 127, 1'b1);
        add_item(-2048, 255, 127, 1'b1);
        add_item(    1,   1,   1, 1'b1);
        add_item(   -1,  16,   1, 1'b1);
        add_item(    5,   0,  20, 1'b1);
        add_item(   -7,  30,   0, 1'b1);
        add_item(    0, 255, 127, 1'b1);
        add_item(    0, 255, 127, 1'b0);
        add_item(    1,   1,   1, 1'b0);
        add_item(   -1, 255, 127, 1'b0);
        add_item( 2047, 255, 127, 1'b0);
        add_item(-2048, 255, 127, 1'b0);
        add_item(  100,   0,  50, 1'b0);
        add_item( -100,  50,   0, 1'b0);
        add_item( 2047,   1,   1, 1'b0);
        add_item(  300,  20,  10, 1'b1);
        add_item(-1366, 8'h55, 7'h2A, 1'b1);
        add_item( 1365, 8'hAA, 7'h55, 1'b0);
        add_item(   -3, 128,  64, 1'b0);
        gen_block(20, 1'b0);
        for (int b = 0; b < 21; b++)
            gen_block(0, ($urandom_range(7) == 0));
        coef_stim_q[500].drain  = 1'b1;
        coef_stim_q[1100].drain = 1'b1;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (coef_stim_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (exp_coef_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
